FILE: rtl/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// shared types and constants of the analog axis auto-calibrating scaler
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int PORTS_DEF      = 4;
  localparam int AXES_PER_PORT  = 4;
  localparam int TRIGS_PER_PORT = 2;

  // reset values of the configuration registers and of the calibration store
  localparam logic [7:0] STICK_MIN_RST  = 8'd40;
  localparam logic [7:0] STICK_MAX_RST  = 8'd215;
  localparam logic [6:0] STICK_DZ_RST   = 7'd3;
  localparam logic [7:0] STICK_SPAN_RST = 8'd20;
  localparam logic [7:0] TRIG_REST_RST  = 8'd40;
  localparam logic [7:0] TRIG_DZ_RST    = 8'd10;

  localparam logic [8:0] CENTER    = 9'd128;
  localparam logic [7:0] FULL      = 8'd255;
  localparam logic [2:0] LAST_CHAN = 3'd5;
  localparam logic [2:0] TRIG_BASE = 3'd4;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_STICK_MIN  = 3'd0,
    CFG_STICK_MAX  = 3'd1,
    CFG_STICK_DZ   = 3'd2,
    CFG_STICK_SPAN = 3'd3,
    CFG_TRIG_REST  = 3'd4,
    CFG_TRIG_DZ    = 3'd5
  } cfg_idx_t;

  // item kinds
  typedef enum logic {
    KIND_SCALE = 1'b0,
    KIND_RECAL = 1'b1
  } kind_t;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_EVAL  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_DONE  = 6'b010000,
    ST_RECAL = 6'b100000
  } state_t;

  // write strobes into the calibration store
  typedef struct packed {
    logic axis_we;
    logic trig_we;
  } cal_wr_t;

endpackage

FILE: rtl/acs_div.sv
// ----------------------------------------------------------------------------
// acs_div
// serial restoring divider, 16-bit dividend by 8-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module acs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,   // must be below den * 256
  input  logic [7:0]  den,
  output logic        done,
  output logic [7:0]  quot
);

  logic [7:0] rem_r, rem_nxt;
  logic [7:0] q_r, q_nxt;
  logic [7:0] den_r;
  logic [2:0] cnt_r;
  logic       busy_r;
  logic       done_r;
  logic [8:0] trial;
  logic       ge;

  assign trial   = {rem_r, q_r[7]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? 8'(trial - {1'b0, den_r}) : trial[7:0];
  assign q_nxt   = {q_r[6:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[15:8];
      q_r   <= num[7:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: rtl/acs_cal_store.sv
// ----------------------------------------------------------------------------
// acs_cal_store
// per-channel calibration memories with valid bits for the reset values
// ----------------------------------------------------------------------------
module acs_cal_store #(
  parameter int PORTS = 4
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  acs_pkg::cal_wr_t                        wr,
  input  logic [$clog2(PORTS*acs_pkg::AXES_PER_PORT)-1:0]  axis_addr,
  input  logic [15:0]                             axis_wdata,  // max, min
  input  logic [$clog2(PORTS*acs_pkg::TRIGS_PER_PORT)-1:0] trig_addr,
  input  logic [7:0]                              trig_wdata,
  output logic [15:0]                             axis_rdata,  // max, min
  output logic [7:0]                              trig_rdata
);
  import acs_pkg::*;

  localparam int AXIS_DEPTH = PORTS * AXES_PER_PORT;
  localparam int TRIG_DEPTH = PORTS * TRIGS_PER_PORT;

  logic [15:0] axis_mem [AXIS_DEPTH];
  logic [7:0]  trig_mem [TRIG_DEPTH];
  logic [AXIS_DEPTH-1:0] axis_vld_r;
  logic [TRIG_DEPTH-1:0] trig_vld_r;
  logic [15:0] axis_q_r;
  logic [7:0]  trig_q_r;
  logic        axis_qv_r;
  logic        trig_qv_r;

  always_ff @(posedge clk) begin
    if (wr.axis_we) axis_mem[axis_addr] <= axis_wdata;
    if (wr.trig_we) trig_mem[trig_addr] <= trig_wdata;
    axis_q_r <= axis_mem[axis_addr];
    trig_q_r <= trig_mem[trig_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_vld_r <= '0;
      trig_vld_r <= '0;
      axis_qv_r  <= 1'b0;
      trig_qv_r  <= 1'b0;
    end else begin
      if (wr.axis_we) axis_vld_r[axis_addr] <= 1'b1;
      if (wr.trig_we) trig_vld_r[trig_addr] <= 1'b1;
      axis_qv_r <= axis_vld_r[axis_addr];
      trig_qv_r <= trig_vld_r[trig_addr];
    end
  end

  // an entry never written since reset reads as the reset calibration
  assign axis_rdata = axis_qv_r ? axis_q_r : {STICK_MAX_RST, STICK_MIN_RST};
  assign trig_rdata = trig_qv_r ? trig_q_r : TRIG_REST_RST;

endmodule

FILE: rtl/analog_axis_autocal_scaler_unit.sv
// ----------------------------------------------------------------------------
// analog_axis_autocal_scaler_unit
// self-calibrating 0..255 scaler for stick axes and analog triggers
// ----------------------------------------------------------------------------
// a result word that needs a division passes through read, evaluate, the
//   8-step serial divider, done and the output register; clipped, zero or
//   pass-through results skip the divider
// the unit takes no new word until the last one is through; a recalibrate word
//   holds the input while it writes the store, one write per axis
// reset (synchronous, rst_n low): control and configuration registers return
//   to defaults; all channels read the default calibration via store valid bits
module analog_axis_autocal_scaler_unit #(
  parameter int PORTS = acs_pkg::PORTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // port[1:0], channel[4:2], raw[12:5], zero pad
  input  logic        in_tuser,   // kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // scaled[7:0]
  output logic        out_tuser,  // passed_through
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import acs_pkg::*;

  localparam int AXIS_AW = $clog2(PORTS * AXES_PER_PORT);
  localparam int TRIG_AW = $clog2(PORTS * TRIGS_PER_PORT);

  // multiply by 255 as a shift and subtract
  function automatic logic [15:0] mul255(input logic [7:0] x);
    mul255 = {x, 8'h00} - {8'h00, x};
  endfunction

  // configuration registers
  logic [7:0] cfg_min_r, cfg_max_r, cfg_span_r, cfg_rest_r, cfg_tdz_r;
  logic [6:0] cfg_sdz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_min_r  <= STICK_MIN_RST;
      cfg_max_r  <= STICK_MAX_RST;
      cfg_sdz_r  <= STICK_DZ_RST;
      cfg_span_r <= STICK_SPAN_RST;
      cfg_rest_r <= TRIG_REST_RST;
      cfg_tdz_r  <= TRIG_DZ_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STICK_MIN:  cfg_min_r  <= cfg_wdata;
        CFG_STICK_MAX:  cfg_max_r  <= cfg_wdata;
        CFG_STICK_DZ:   cfg_sdz_r  <= cfg_wdata[6:0];
        CFG_STICK_SPAN: cfg_span_r <= cfg_wdata;
        CFG_TRIG_REST:  cfg_rest_r <= cfg_wdata;
        CFG_TRIG_DZ:    cfg_tdz_r  <= cfg_wdata;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // sequencer state and item fields
  state_t     state_r, state_nxt;
  logic [1:0] port_r;
  logic [2:0] chan_r;
  logic [7:0] raw_r;
  logic [1:0] cnt_r;        // recalibrate sweep over the port's channels
  logic [7:0] res_r;
  logic       pass_r;
  logic [7:0] out_data_r;
  logic       out_pass_r;
  logic       out_vld_r;

  logic [1:0] in_port;
  logic [2:0] in_chan;
  logic       in_acc;
  logic       port_ok;

  assign in_port   = in_tdata[1:0];
  assign in_chan   = in_tdata[4:2];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign port_ok   = 5'(in_port) < 5'(PORTS);

  // calibration store
  cal_wr_t              wr;
  logic [AXIS_AW-1:0]   axis_addr;
  logic [TRIG_AW-1:0]   trig_addr;
  logic [15:0]          axis_wdata, axis_rdata;
  logic [7:0]           trig_wdata, trig_rdata;
  logic [5:0]           axis_idx;
  logic [4:0]           trig_idx;
  logic                 recal;

  assign recal     = (state_r == ST_RECAL);
  // index is port * channels + channel, as a concatenation
  assign axis_idx  = {2'b00, port_r, recal ? cnt_r : chan_r[1:0]};
  assign trig_idx  = {2'b00, port_r, recal ? cnt_r[0] : chan_r[0]};
  assign axis_addr = axis_idx[AXIS_AW-1:0];
  assign trig_addr = trig_idx[TRIG_AW-1:0];

  acs_cal_store #(
    .PORTS(PORTS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .axis_addr (axis_addr),
    .axis_wdata(axis_wdata),
    .trig_addr (trig_addr),
    .trig_wdata(trig_wdata),
    .axis_rdata(axis_rdata),
    .trig_rdata(trig_rdata)
  );

  // stick evaluation: widen range outside the centre dead zone
  logic [7:0] lo0, hi0, lo, hi, span;
  logic       train, degen;

  assign lo0   = axis_rdata[7:0];
  assign hi0   = axis_rdata[15:8];
  assign train = ((9'(raw_r) + 9'(cfg_sdz_r)) < CENTER) ||
                 (9'(raw_r) > (CENTER + 9'(cfg_sdz_r)));
  assign lo    = (train && raw_r < lo0) ? raw_r : lo0;
  assign hi    = (train && raw_r > hi0) ? raw_r : hi0;
  assign span  = hi - lo;
  assign degen = (hi <= lo) || (span < cfg_span_r);

  // trigger evaluation: rest follows the lowest sample seen
  logic [7:0] rest;
  logic [8:0] floor_v;
  logic       trig_zero;

  assign rest      = (raw_r < trig_rdata) ? raw_r : trig_rdata;
  assign floor_v   = 9'(rest) + 9'(cfg_tdz_r);
  assign trig_zero = 9'(raw_r) <= floor_v;

  // shared divider
  logic        div_start;
  logic [15:0] div_num;
  logic [7:0]  div_den;
  logic        div_done;
  logic [7:0]  div_quot;
  logic        is_trig;

  assign is_trig = chan_r[2];

  always_comb begin
    if (is_trig) begin
      div_num = mul255(8'(raw_r - floor_v[7:0]));
      div_den = FULL - floor_v[7:0];
    end else begin
      div_num = mul255(8'(raw_r - lo));
      div_den = span;
    end
  end

  acs_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  // store write data: eval writes back the trained values, recal the configured ones
  always_comb begin
    wr         = '0;
    axis_wdata = {hi, lo};
    trig_wdata = rest;
    if (recal) begin
      wr.axis_we = 1'b1;
      wr.trig_we = (cnt_r < 2'(TRIGS_PER_PORT));
      axis_wdata = {cfg_max_r, cfg_min_r};
      trig_wdata = cfg_rest_r;
    end else if (state_r == ST_EVAL) begin
      wr.axis_we = !is_trig;
      wr.trig_we = is_trig;
    end
  end

  // sequencer
  logic out_free;
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && port_ok) begin
          if (in_tuser == KIND_RECAL) state_nxt = ST_RECAL;
          else if (in_chan <= LAST_CHAN) state_nxt = ST_READ;
        end
      end
      ST_READ:  state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (is_trig) begin
          if (trig_zero) state_nxt = ST_DONE;
          else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end else if (degen || raw_r <= lo || raw_r >= hi) begin
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:   if (div_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      ST_RECAL: if (cnt_r == 2'(AXES_PER_PORT - 1)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) cnt_r <= '0;
      else if (recal) cnt_r <= cnt_r + 2'd1;
      if (state_r == ST_DONE && out_free) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      port_r <= in_port;
      chan_r <= in_chan;
      raw_r  <= in_tdata[12:5];
    end
    if (state_r == ST_EVAL) begin
      pass_r <= 1'b0;
      if (is_trig) res_r <= '0;
      else if (degen) begin
        res_r  <= raw_r;
        pass_r <= 1'b1;
      end else if (raw_r <= lo) res_r <= '0;
      else res_r <= FULL;
    end else if (state_r == ST_DIV && div_done) begin
      res_r <= div_quot;
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= res_r;
      out_pass_r <= pass_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_pass_r;

endmodule
